[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define PCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Next-cycle implication.
`define PCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    `PCE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hdl/pce_pkg.sv]
// ----------------------------------------------------------------------------
// pce_pkg
// Widths, op codes and fixed-point constants of the Chebyshev evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pce_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 24;
    localparam int MAX_SEG   = 64;
    localparam int MAX_COEF  = 16;
    localparam int SEG_W     = 6;
    localparam int CI_W      = 4;
    localparam int OP_W      = 2;
    localparam int CADDR_W   = SEG_W + CI_W;
    localparam int NSEG_W    = 7;
    localparam int NCOEF_W   = 5;

    localparam logic [OP_W-1:0] OP_EVAL  = 2'd0;
    localparam logic [OP_W-1:0] OP_LB    = 2'd1;
    localparam logic [OP_W-1:0] OP_UB    = 2'd2;
    localparam logic [OP_W-1:0] OP_COEF  = 2'd3;

    localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] ONE  = 32'sh0100_0000;

    typedef logic signed [VALUE_W-1:0] t_val;

endpackage

[hdl/pce_in_if.sv]
// ----------------------------------------------------------------------------
// pce_in_if
// Request channel: op, segment, coefficient index and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pce_in_if;
    logic                         valid;
    logic                         ready;
    logic [pce_pkg::OP_W-1:0]     op;
    logic [pce_pkg::SEG_W-1:0]    segment;
    logic [pce_pkg::CI_W-1:0]     coeff_index;
    logic signed [pce_pkg::VALUE_W-1:0] value;

    modport source (output valid, op, segment, coeff_index, value, input ready);
    modport sink   (input valid, op, segment, coeff_index, value, output ready);
endinterface

[hdl/pce_out_if.sv]
// ----------------------------------------------------------------------------
// pce_out_if
// Result channel: value, chosen segment and range flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pce_out_if;
    logic                         valid;
    logic                         ready;
    logic signed [pce_pkg::VALUE_W-1:0] result;
    logic [pce_pkg::SEG_W-1:0]    segment_used;
    logic                         out_of_range;

    modport source (output valid, result, segment_used, out_of_range, input ready);
    modport sink   (input valid, result, segment_used, out_of_range, output ready);
endinterface

[hdl/pce_ram.sv]
// ----------------------------------------------------------------------------
// pce_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/piecewise_chebyshev_evaluator.sv]
// ----------------------------------------------------------------------------
// piecewise_chebyshev_evaluator
// Segment table search, Q7.24 argument mapping and Clenshaw evaluation.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// i_req     in   op, segment, coeff_index, value
// o_rsp     out  result, segment_used, out_of_range (evaluate beats only)
// APB       in   reg 0 num_segments @0x0, reg 1 num_coeffs @0x4
//
// Load beats write the bound or coefficient RAM directly.
// An evaluate beat runs the binary search (each step one RAM read, then a
// compare), the one-bit-per-cycle restoring divider for t (skipped for an
// empty segment) and the Clenshaw steps on the shared multiplier and
// coefficient RAM port. One item is in flight at a time.
// Reset (synchronous, active low) clears control and the registers only; the
// tables are undefined until loaded. A stalled result sits in the output
// register and the next beat is still taken; a new result waits for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module piecewise_chebyshev_evaluator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pce_in_if.sink            i_req,
    pce_out_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_BCAP  = 4'd3;
    localparam logic [3:0] S_DINIT = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_T     = 4'd6;
    localparam logic [3:0] S_C0    = 4'd7;
    localparam logic [3:0] S_C1    = 4'd8;
    localparam logic [3:0] S_C2    = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    localparam int DVD_W = pce_pkg::VALUE_W + pce_pkg::FRAC_BITS + 1;  // 57
    localparam int SW    = pce_pkg::SEG_W;
    localparam int CW    = pce_pkg::CI_W;

    // ---------------- saturating helpers ----------------
    function automatic pce_pkg::t_val sat_add(pce_pkg::t_val a, pce_pkg::t_val b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) return s[32] ? pce_pkg::VMIN : pce_pkg::VMAX;
        return s[31:0];
    endfunction

    function automatic pce_pkg::t_val sat_sub(pce_pkg::t_val a, pce_pkg::t_val b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31]) return s[32] ? pce_pkg::VMIN : pce_pkg::VMAX;
        return s[31:0];
    endfunction

    // product / 2^24, rounded half away from zero, saturated
    function automatic pce_pkg::t_val fx_round(logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] s;
        logic [39:0] q;
        mag = p[63] ? (64'd0 - p) : p;
        s   = mag + 64'(1 << (pce_pkg::FRAC_BITS - 1));
        q   = s[63:pce_pkg::FRAC_BITS];
        if (p[63]) begin
            if (q > 40'h0080000000) return pce_pkg::VMIN;
            return 32'(0) - q[31:0];
        end
        if (q > 40'h007FFFFFFF) return pce_pkg::VMAX;
        return q[31:0];
    endfunction

    // ---------------- configuration ----------------
    logic [pce_pkg::NSEG_W-1:0]  r_ns;
    logic [pce_pkg::NCOEF_W-1:0] r_nc;
    logic                        cfg_we;

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {27'd0, r_nc} : {25'd0, r_ns};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ns <= 7'd1;
            r_nc <= 5'd12;
        end else if (cfg_we) begin
            if (paddr[2]) r_nc <= pwdata[4:0];
            else          r_ns <= pwdata[6:0];
        end
    end

    // clamped segment count minus one and coefficient count
    logic [SW-1:0] n_last;
    logic [CW:0]   m_eff;
    always_comb begin
        if (r_ns == 7'd0)      n_last = '0;
        else if (r_ns > 7'd64) n_last = 6'd63;
        else                   n_last = SW'(r_ns - 7'd1);
        if (r_nc < 5'd2)       m_eff = 5'd2;
        else if (r_nc > 5'd16) m_eff = 5'd16;
        else                   m_eff = r_nc;
    end

    // ---------------- state ----------------
    logic [3:0]           r_state;
    pce_pkg::t_val        r_x, r_num, r_den, r_t, r_x2, r_c0, r_c1;
    logic [SW-1:0]        r_lo, r_hi, r_mid;
    logic                 r_oor, r_neg, r_zden;
    logic [DVD_W-1:0]     r_dvd;
    logic [31:0]          r_rem, r_dmag;
    logic [5:0]           r_dcnt;
    logic [CW-1:0]        r_k;
    logic signed [63:0]   r_prod;
    logic                 r_ovalid;
    pce_pkg::t_val        r_ores;
    logic [SW-1:0]        r_oseg;
    logic                 r_ooor;

    logic                 acc;
    logic [SW:0]          mid_sum;
    pce_pkg::t_val        lb_rdata, ub_rdata, cf_rdata;
    logic [SW-1:0]        lb_raddr;
    logic [pce_pkg::CADDR_W-1:0] cf_raddr;
    logic [32:0]          rem_s;
    logic                 qbit;
    pce_pkg::t_val        ratio, num_c, den_c;
    logic                 out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;
    assign mid_sum     = {1'b0, r_lo} + {1'b0, r_hi} + 7'd1;
    assign lb_raddr    = (r_lo < r_hi) ? mid_sum[SW:1] : r_lo;

    always_comb begin
        case (r_state)
            S_C0:    cf_raddr = {r_lo, CW'(m_eff - 5'd2)};
            S_C1:    cf_raddr = {r_lo, CW'(m_eff - 5'd1)};
            default: cf_raddr = {r_lo, CW'(r_k - 4'd1)};
        endcase
    end

    // divider step: remainder stays below the divisor (<= 2^31)
    assign rem_s = {r_rem, r_dvd[DVD_W-1]};
    assign qbit  = (rem_s >= {1'b0, r_dmag});

    // quotient magnitude back to a signed, saturated ratio
    always_comb begin
        if (r_zden) begin
            if (r_num == '0)  ratio = '0;
            else if (r_num[31]) ratio = pce_pkg::VMIN;
            else              ratio = pce_pkg::VMAX;
        end else if (r_neg) begin
            if (r_dvd >= DVD_W'(64'h8000_0000)) ratio = pce_pkg::VMIN;
            else ratio = 32'(0) - r_dvd[31:0];
        end else begin
            if (r_dvd > DVD_W'(64'h7FFF_FFFF)) ratio = pce_pkg::VMAX;
            else ratio = r_dvd[31:0];
        end
    end

    assign num_c = sat_sub(r_x, lb_rdata);
    assign den_c = sat_sub(ub_rdata, lb_rdata);

    // ---------------- memories ----------------
    pce_ram #(.WIDTH(pce_pkg::VALUE_W), .DEPTH(pce_pkg::MAX_SEG)) u_lb_ram (
        .i_clk   (i_clk),
        .i_we    (acc && i_req.op == pce_pkg::OP_LB),
        .i_waddr (i_req.segment),
        .i_wdata (i_req.value),
        .i_raddr (lb_raddr),
        .o_rdata (lb_rdata)
    );

    pce_ram #(.WIDTH(pce_pkg::VALUE_W), .DEPTH(pce_pkg::MAX_SEG)) u_ub_ram (
        .i_clk   (i_clk),
        .i_we    (acc && i_req.op == pce_pkg::OP_UB),
        .i_waddr (i_req.segment),
        .i_wdata (i_req.value),
        .i_raddr (r_lo),
        .o_rdata (ub_rdata)
    );

    pce_ram #(.WIDTH(pce_pkg::VALUE_W),
              .DEPTH(pce_pkg::MAX_SEG * pce_pkg::MAX_COEF)) u_cf_ram (
        .i_clk   (i_clk),
        .i_we    (acc && i_req.op == pce_pkg::OP_COEF),
        .i_waddr ({i_req.segment, i_req.coeff_index}),
        .i_wdata (i_req.value),
        .i_raddr (cf_raddr),
        .o_rdata (cf_rdata)
    );

    // ---------------- result register valid ----------------
    // set at the final step, cleared once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc && i_req.op == pce_pkg::OP_EVAL) begin
                        r_x     <= i_req.value;
                        r_lo    <= '0;
                        r_hi    <= n_last;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    // lb RAM reads mid, or the final segment's bound
                    r_mid   <= mid_sum[SW:1];
                    r_state <= (r_lo < r_hi) ? S_SCMP : S_BCAP;
                end
                S_SCMP: begin
                    if (lb_rdata <= r_x) r_lo <= r_mid;
                    else                 r_hi <= r_mid - 6'd1;
                    r_state <= S_SRD;
                end
                S_BCAP: begin
                    r_num   <= num_c;
                    r_den   <= den_c;
                    r_oor   <= (r_x < lb_rdata) || (r_x > ub_rdata);
                    r_state <= S_DINIT;
                end
                S_DINIT: begin
                    r_zden  <= (r_den == '0);
                    r_neg   <= r_num[31] ^ r_den[31];
                    r_dmag  <= r_den[31] ? 32'd0 - r_den : r_den;
                    r_dvd   <= {(r_num[31] ? 32'd0 - r_num : r_num),
                                {(pce_pkg::FRAC_BITS + 1){1'b0}}};
                    r_rem   <= '0;
                    r_dcnt  <= 6'(DVD_W - 1);
                    r_state <= (r_den == '0) ? S_T : S_DIV;
                end
                S_DIV: begin
                    r_rem   <= qbit ? 32'(rem_s - {1'b0, r_dmag}) : rem_s[31:0];
                    r_dvd   <= {r_dvd[DVD_W-2:0], qbit};
                    r_dcnt  <= r_dcnt - 6'd1;
                    if (r_dcnt == '0) r_state <= S_T;
                end
                S_T: begin
                    r_t     <= sat_sub(ratio, pce_pkg::ONE);
                    r_state <= S_C0;
                end
                S_C0: begin
                    r_x2    <= sat_add(r_t, r_t);
                    r_state <= S_C1;
                end
                S_C1: begin
                    r_c0    <= cf_rdata;
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_c1    <= cf_rdata;
                    r_k     <= CW'(m_eff - 5'd2);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_k != '0) begin
                        r_prod  <= r_c1 * r_x2;
                        r_state <= S_ACC;
                    end else begin
                        r_prod  <= r_c1 * r_t;
                        r_state <= S_FIN;
                    end
                end
                S_ACC: begin
                    r_c0    <= sat_sub(cf_rdata, r_c1);
                    r_c1    <= sat_add(r_c0, fx_round(r_prod));
                    r_k     <= r_k - 4'd1;
                    r_state <= S_MUL;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ores   <= sat_add(r_c0, fx_round(r_prod));
                        r_oseg   <= r_lo;
                        r_ooor   <= r_oor;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.result       = r_ores;
    assign o_rsp.segment_used = r_oseg;
    assign o_rsp.out_of_range = r_ooor;

    // ---------------- checks ----------------
    `PCE_ASSERT(a_search_order, (r_state == S_SCMP) |-> (r_lo < r_hi),
        "search compare with empty interval")
    `PCE_ASSERT_NEXT(a_eval_busy, acc && (i_req.op == pce_pkg::OP_EVAL),
        r_state != S_IDLE, "evaluate beat did not start the sequencer")
    `PCE_ASSERT(a_out_from_fin, $rose(r_ovalid) |-> ($past(r_state) == S_FIN),
        "result loaded outside the final step")
    `PCE_ASSERT(a_div_count, (r_state == S_DIV) |-> (r_dcnt <= 6'(DVD_W - 1)),
        "divider step count out of range")

endmodule

[dv/piecewise_chebyshev_evaluator_tb.sv]
// ----------------------------------------------------------------------------
// piecewise_chebyshev_evaluator_tb
// Self-checking bench: loads segment tables, evaluates arguments and checks
// every result beat against a bit-exact Q7.24 Clenshaw predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_chebyshev_evaluator_tb;

    localparam logic [2:0] REG_NSEG  = 3'd0;
    localparam logic [2:0] REG_NCOEF = 3'd1;
    localparam longint     VMAX_L    = 64'sd2147483647;
    localparam longint     VMIN_L    = -64'sd2147483648;
    localparam longint     ONE_L     = 64'sd16777216;
    localparam int         DRAIN     = 200;   // cycles

    typedef struct {
        logic [pce_pkg::OP_W-1:0]  op;
        logic [pce_pkg::SEG_W-1:0] seg;
        logic [pce_pkg::CI_W-1:0]  ci;
        pce_pkg::t_val             value;
    } t_req_beat;

    typedef struct {
        pce_pkg::t_val             result;
        logic [pce_pkg::SEG_W-1:0] seg;
        logic                      oor;
    } t_eval_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    pce_in_if  req_if ();
    pce_out_if rsp_if ();

    piecewise_chebyshev_evaluator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state, updated as beats are accepted
    longint lb_tab [pce_pkg::MAX_SEG];
    longint ub_tab [pce_pkg::MAX_SEG];
    longint coef_tab [pce_pkg::MAX_SEG*pce_pkg::MAX_COEF];
    logic [pce_pkg::NSEG_W-1:0]  cfg_nseg  = 7'd1;
    logic [pce_pkg::NCOEF_W-1:0] cfg_ncoef = 5'd12;

    // Stimulus-side copy of the bounds, current as of the last queued beat
    longint plan_lb [pce_pkg::MAX_SEG];
    longint plan_ub [pce_pkg::MAX_SEG];

    t_req_beat    pending_beats [$];
    t_eval_result expected_evals [$];

    int  errors = 0;
    int  evals_checked = 0;
    int  loads_applied = 0;
    bit  idle_en  = 1'b1;
    bit  stall_en = 1'b1;

    // ------------------------------------------------------------------
    // Saturating Q7.24 arithmetic
    // ------------------------------------------------------------------
    function automatic longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        return s > VMAX_L ? VMAX_L : (s < VMIN_L ? VMIN_L : s);
    endfunction

    function automatic longint sat_sub(longint a, longint b);
        longint s;
        s = a - b;
        return s > VMAX_L ? VMAX_L : (s < VMIN_L ? VMIN_L : s);
    endfunction

    function automatic longint from_mag(longint unsigned mag, bit neg);
        if (neg) return mag >= 64'd2147483648 ? VMIN_L : -longint'(mag);
        return mag > 64'd2147483647 ? VMAX_L : longint'(mag);
    endfunction

    // product, rounded to nearest with ties away from zero
    function automatic longint q_mul(longint a, longint b);
        longint          p;
        longint unsigned mag;
        p   = a * b;
        mag = p < 0 ? longint'(-p) : p;
        mag = (mag + 64'd8388608) >> pce_pkg::FRAC_BITS;
        return from_mag(mag, p < 0);
    endfunction

    // 2*num/den truncated toward zero
    function automatic longint q_ratio(longint num, longint den);
        longint unsigned n, d;
        if (den == 0) return num > 0 ? VMAX_L : (num < 0 ? VMIN_L : 0);
        n = (num < 0 ? -num : num) << (pce_pkg::FRAC_BITS + 1);
        d = den < 0 ? -den : den;
        return from_mag(n / d, (num < 0) != (den < 0));
    endfunction

    function automatic t_eval_result chebyshev_predict(longint x);
        int           n, m, lo, hi, mid, k;
        longint       lb, ub, t, x2, c0, c1, tmp;
        t_eval_result r;
        n = cfg_nseg;
        if (n < 1) n = 1;
        if (n > pce_pkg::MAX_SEG) n = pce_pkg::MAX_SEG;
        m = cfg_ncoef;
        if (m < 2) m = 2;
        if (m > pce_pkg::MAX_COEF) m = pce_pkg::MAX_COEF;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (lb_tab[mid] <= x) lo = mid;
            else hi = mid - 1;
        end
        lb = lb_tab[lo];
        ub = ub_tab[lo];
        t  = sat_sub(q_ratio(sat_sub(x, lb), sat_sub(ub, lb)), ONE_L);
        x2 = sat_add(t, t);
        c0 = coef_tab[lo*pce_pkg::MAX_COEF + m - 2];
        c1 = coef_tab[lo*pce_pkg::MAX_COEF + m - 1];
        for (k = m - 2; k > 0; k--) begin
            tmp = c0;
            c0  = sat_sub(coef_tab[lo*pce_pkg::MAX_COEF + k - 1], c1);
            c1  = sat_add(tmp, q_mul(c1, x2));
        end
        r.result = pce_pkg::t_val'(sat_add(c0, q_mul(c1, t)));
        r.seg    = lo[pce_pkg::SEG_W-1:0];
        r.oor    = (x < lb) || (x > ub);
        return r;
    endfunction

    // Apply one accepted beat to the predictor
    function automatic void absorb_beat(t_req_beat b);
        case (b.op)
            pce_pkg::OP_EVAL: expected_evals = {expected_evals,
                                                chebyshev_predict(longint'(b.value))};
            pce_pkg::OP_LB:   lb_tab[b.seg] = b.value;
            pce_pkg::OP_UB:   ub_tab[b.seg] = b.value;
            pce_pkg::OP_COEF: coef_tab[{b.seg, b.ci}] = b.value;
            default: ;
        endcase
        if (b.op != pce_pkg::OP_EVAL) loads_applied++;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of beats with random gaps
    // ------------------------------------------------------------------
    t_req_beat cur_beat;
    int        burst_left = 4;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) absorb_beat(cur_beat);
            if (!(req_if.valid && !req_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    cur_beat = pending_beats.pop_front();
                    req_if.op          <= cur_beat.op;
                    req_if.segment     <= cur_beat.seg;
                    req_if.coeff_index <= cur_beat.ci;
                    req_if.value       <= cur_beat.value;
                    req_if.valid       <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = idle_en ? $urandom_range(0, 12) : 0;
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks result beats, receiver stalls in on/off runs
    // ------------------------------------------------------------------
    int on_left  = 0;
    int off_left = 0;

    task automatic flag_mismatch(string what, longint want, longint got);
        errors++;
        if (errors <= 10)
            $display("MISMATCH %s: expected %0d (0x%0h) got %0d (0x%0h) at %0t",
                     what, want, want, got, got, $realtime);
    endtask

    always @(posedge i_clk) begin : monitor
        t_eval_result want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_evals.size() == 0) begin
                    flag_mismatch("unexpected result beat", 0, rsp_if.result);
                end else begin
                    want = expected_evals.pop_front();
                    evals_checked++;
                    if (rsp_if.result !== want.result)
                        flag_mismatch("result", want.result, rsp_if.result);
                    if (rsp_if.segment_used !== want.seg)
                        flag_mismatch("segment_used", want.seg, rsp_if.segment_used);
                    if (rsp_if.out_of_range !== want.oor)
                        flag_mismatch("out_of_range", want.oor, rsp_if.out_of_range);
                end
            end
            if (!stall_en) begin
                rsp_if.ready <= 1'b1;
            end else if (on_left > 0) begin
                on_left--;
                rsp_if.ready <= 1'b1;
            end else if (off_left > 0) begin
                off_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                on_left  = $urandom_range(0, 10);
                off_left = $urandom_range(1, 9);
                rsp_if.ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_beat(logic [pce_pkg::OP_W-1:0] op, int seg, int ci,
                                       longint v);
        t_req_beat b;
        b.op    = op;
        b.seg   = seg[pce_pkg::SEG_W-1:0];
        b.ci    = ci[pce_pkg::CI_W-1:0];
        b.value = pce_pkg::t_val'(v);
        if (op == pce_pkg::OP_LB) plan_lb[seg] = b.value;
        if (op == pce_pkg::OP_UB) plan_ub[seg] = b.value;
        pending_beats = {pending_beats, b};
    endfunction

    function automatic longint rand_value();
        return longint'($signed($urandom()));
    endfunction

    // Mostly modest magnitudes, some large ones to push saturation
    function automatic longint rand_coef();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return longint'($urandom_range(0, 1 << 26)) - (1 << 25);
        if (sel < 85) return longint'($urandom_range(0, 1 << 29)) - (1 << 28);
        return rand_value();
    endfunction

    // Argument inside a segment, at its edges, or anywhere at all
    function automatic longint pick_arg(int nseg);
        int     s, sel;
        longint lb, ub;
        s   = $urandom_range(0, nseg - 1);
        lb  = plan_lb[s];
        ub  = plan_ub[s];
        sel = $urandom_range(0, 99);
        if (sel < 65 && ub > lb) return lb + ($urandom() % (ub - lb + 1));
        if (sel < 85) begin
            case ($urandom_range(0, 3))
                0: return sat_sub(lb, 1);
                1: return lb;
                2: return ub;
                default: return sat_add(ub, 1);
            endcase
        end
        return rand_value();
    endfunction

    // Ascending table with random widths, occasional gaps and empty segments
    function automatic void queue_layout(int nseg);
        longint cursor, w, wmax;
        cursor = -(longint'(1) << 30) + $urandom_range(0, 1 << 20);
        wmax   = longint'(1) << $urandom_range(4, 24);
        for (int i = 0; i < nseg; i++) begin
            w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, wmax);
            queue_beat(pce_pkg::OP_LB, i, $urandom_range(0, 15), cursor);
            queue_beat(pce_pkg::OP_UB, i, $urandom_range(0, 15), cursor + w);
            cursor = cursor + w + (($urandom_range(0, 3) == 0) ? $urandom_range(1, wmax) : 1);
        end
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= idx << 2;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NSEG) cfg_nseg = data[pce_pkg::NSEG_W-1:0];
        else cfg_ncoef = data[pce_pkg::NCOEF_W-1:0];
    endtask

    // Sender holds off until the block has drained, then lets it settle
    task automatic wait_drained();
        while (pending_beats.size() != 0 || req_if.valid || expected_evals.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    int phase_nseg [8] = '{0, 64, 127, 100, 2, 64, 1, 33};
    int phase_ncoef[8] = '{0, 16, 31, 1, 2, 17, 5, 12};

    initial begin : stimulus
        int nseg, ncoef, neff;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every coefficient; bounds are loaded before any search reads them
        for (int s = 0; s < pce_pkg::MAX_SEG; s++) begin
            for (int c = 0; c < pce_pkg::MAX_COEF; c++)
                queue_beat(pce_pkg::OP_COEF, s, c, rand_coef());
        end

        // Directed: extremes, edges, empty and reversed segment (reset config)
        queue_beat(pce_pkg::OP_LB, 0, 0, -ONE_L);
        queue_beat(pce_pkg::OP_UB, 0, 0, ONE_L);
        queue_beat(pce_pkg::OP_COEF, 0, 15, VMAX_L);
        queue_beat(pce_pkg::OP_COEF, 0, 0, VMIN_L);
        queue_beat(pce_pkg::OP_COEF, 63, 15, 0);
        queue_beat(pce_pkg::OP_EVAL, 0, 0, 0);
        queue_beat(pce_pkg::OP_EVAL, 63, 15, VMAX_L);
        queue_beat(pce_pkg::OP_EVAL, 0, 0, VMIN_L);
        queue_beat(pce_pkg::OP_EVAL, 0, 0, -ONE_L);
        queue_beat(pce_pkg::OP_EVAL, 0, 0, ONE_L);
        queue_beat(pce_pkg::OP_EVAL, 0, 0, ONE_L + 1);
        queue_beat(pce_pkg::OP_LB, 0, 0, ONE_L);                  // empty segment
        queue_beat(pce_pkg::OP_EVAL, 0, 0, ONE_L);
        queue_beat(pce_pkg::OP_EVAL, 0, 0, ONE_L + 1);
        queue_beat(pce_pkg::OP_EVAL, 0, 0, ONE_L - 1);
        queue_beat(pce_pkg::OP_UB, 0, 0, -ONE_L);                 // reversed bounds
        queue_beat(pce_pkg::OP_EVAL, 0, 0, 0);
        queue_beat(pce_pkg::OP_EVAL, 0, 0, VMIN_L);
        queue_beat(pce_pkg::OP_LB, 0, 0, -ONE_L);
        queue_beat(pce_pkg::OP_UB, 0, 0, ONE_L);
        queue_beat(pce_pkg::OP_EVAL, 0, 0, ONE_L >>> 1);

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            nseg  = phase_nseg[ph];
            ncoef = phase_ncoef[ph];
            apb_write(REG_NSEG, nseg);
            apb_write(REG_NCOEF, ncoef);
            idle_en  = (ph % 3) != 1;
            stall_en = (ph % 4) != 2;
            neff = nseg < 1 ? 1 : (nseg > pce_pkg::MAX_SEG ? pce_pkg::MAX_SEG : nseg);
            queue_layout(neff);
            for (int i = 0; i < 40; i++) begin
                case ($urandom_range(0, 9))
                    0, 1:    queue_beat(pce_pkg::OP_COEF, $urandom_range(0, 63),
                                        $urandom_range(0, 15), rand_coef());
                    2:       queue_beat($urandom_range(0, 1) ? pce_pkg::OP_LB : pce_pkg::OP_UB,
                                        $urandom_range(0, 63), $urandom_range(0, 15),
                                        rand_value());
                    default: queue_beat(pce_pkg::OP_EVAL, $urandom_range(0, 63),
                                        $urandom_range(0, 15), pick_arg(neff));
                endcase
            end
        end

        wait_drained();
        $display("Checked %0d evaluate results after %0d table loads,", evals_checked,
                 loads_applied);
        $display("over 9 register settings with random source gaps and sink stalls.");
        if (errors == 0 && expected_evals.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #8ms;
        $display("Timeout with %0d results outstanding", expected_evals.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

[piecewise_chebyshev_evaluator.f]
+incdir+hdl
hdl/pce_pkg.sv
hdl/pce_in_if.sv
hdl/pce_out_if.sv
hdl/pce_ram.sv
hdl/piecewise_chebyshev_evaluator.sv
dv/piecewise_chebyshev_evaluator_tb.sv
